// File: rtl/whp_pkg.sv
package whp_pkg;
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindStart  = 2'd1;
  localparam logic [1:0] KindEnd    = 2'd2;

  localparam logic [3:0] StOk        = 4'd0;
  localparam logic [3:0] StRiff      = 4'd1;
  localparam logic [3:0] StWave      = 4'd2;
  localparam logic [3:0] StCodec     = 4'd3;
  localparam logic [3:0] StTag       = 4'd4;
  localparam logic [3:0] StExtShort  = 4'd5;
  localparam logic [3:0] StValidBits = 4'd6;
  localparam logic [3:0] StSubformat = 4'd7;
  localparam logic [3:0] StChannels  = 4'd8;
  localparam logic [3:0] StBits      = 4'd9;
  localparam logic [3:0] StRate      = 4'd10;
  localparam logic [3:0] StZeroAlign = 4'd11;
  localparam logic [3:0] StTrunc     = 4'd12;
  localparam logic [3:0] StNoData    = 4'd13;

  localparam logic [15:0] CodecPcm   = 16'h0001;
  localparam logic [15:0] CodecFloat = 16'h0003;
  localparam logic [15:0] CodecExt   = 16'hFFFE;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [31:0] sample_count;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] sample_rate;
    logic [3:0]  status;
    logic        last;
  } rec_t;

  function automatic logic [7:0] pcm_guid(input logic [3:0] i);
    case (i)
      4'd0: pcm_guid = 8'h01;
      4'd6: pcm_guid = 8'h10;
      4'd8: pcm_guid = 8'h80;
      4'd11: pcm_guid = 8'hAA;
      4'd13: pcm_guid = 8'h38;
      4'd14: pcm_guid = 8'h9B;
      4'd15: pcm_guid = 8'h71;
      default: pcm_guid = 8'h00;
    endcase
  endfunction
endpackage

// File: rtl/whp_div.sv
// restoring divider, one quotient bit a cycle
module whp_div import whp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// File: rtl/wave_header_parser_core.sv
// A header or sample byte is accepted, and any result it makes is registered before it shows.
// The end of a fmt chunk shorter than 18 bytes runs two divides before the next byte is
// taken; a data chunk header runs one before its start record; both waits are set by
// the shared divider.
// Throughput: one byte per cycle otherwise, ready drops while a result waits.
// Reset: asynchronous active low; parser returns to file head, required_rate = 44100.
module wave_header_parser_core import whp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_value
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // sample[15:0], sample_count[47:16], channel_count[63:48], sample_bits[79:64],
  // sample_rate[111:80], status[115:112], zero fill to 120
  output logic [119:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o,   // last
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  // phases
  localparam logic [3:0] PhHead = 4'd0, PhChdr = 4'd1, PhFmt = 4'd2, PhData = 4'd3,
                         PhSkip = 4'd4, PhPad = 4'd5, PhHalt = 4'd6;
  // sequencer: byte accept, divides, then result emission
  localparam logic [2:0] SqIdle = 3'd0, SqDiv1 = 3'd1, SqDiv2 = 3'd2, SqDivD = 3'd3,
                         SqOut = 3'd4;

  logic [31:0] req_rate_q;
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == 2'd0) ? req_rate_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) req_rate_q <= 32'd44100;
    else if (psel_i && penable_i && pwrite_i && paddr_i == 2'd0) req_rate_q <= pwdata_i;
  end

  logic [3:0]  ph_q, ph_d;
  logic [2:0]  sq_q, sq_d;
  logic [31:0] off_q, off_d, tag_q, tag_d, len_q, len_d, rate_q, rate_d, brate_q, brate_d;
  logic [31:0] left_q, left_d;
  logic [15:0] fc_q, fc_d, ch_q, ch_d, al_q, al_d, bits_q, bits_d, ext_q, ext_d;
  logic [15:0] vb_q, vb_d;
  logic [7:0]  lo_q, lo_d;
  logic        gm_q, gm_d, acc_q, acc_d, lastp_q, lastp_d;
  logic [3:0]  err_q, err_d;
  // up to two pending results
  rec_t        r0_q, r0_d, r1_q, r1_d;
  logic [1:0]  nres_q, nres_d;

  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quo;

  whp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  wire in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  wire out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (sq_q == SqIdle) && (nres_q == 2'd0);
  assign m_axis_tvalid_o = (sq_q == SqOut) && (nres_q != 2'd0);
  assign m_axis_tuser_o  = r0_q.kind;
  assign m_axis_tlast_o  = r0_q.last;
  assign m_axis_tdata_o  = {4'd0, r0_q.status, r0_q.sample_rate, r0_q.sample_bits,
                            r0_q.channel_count, r0_q.sample_count, r0_q.sample};

  function automatic logic [31:0] pb(input logic [31:0] f, input logic [1:0] k,
                                     input logic [7:0] b);
    logic [31:0] r;
    r = f;
    r[k*8 +: 8] = b;
    return r;
  endfunction

  logic [31:0] offn, cnt, pairs;
  logic        fail_f;
  logic [3:0]  fcode;
  rec_t        er;

  always_comb begin
    ph_d = ph_q; sq_d = sq_q; off_d = off_q; tag_d = tag_q; len_d = len_q;
    fc_d = fc_q; ch_d = ch_q; rate_d = rate_q; brate_d = brate_q; al_d = al_q;
    bits_d = bits_q; ext_d = ext_q; vb_d = vb_q; gm_d = gm_q; lo_d = lo_q;
    left_d = left_q; err_d = err_q; acc_d = acc_q; lastp_d = lastp_q;
    r0_d = r0_q; r1_d = r1_q; nres_d = nres_q;
    div_start = 1'b0; div_num = brate_q; div_den = rate_q;
    offn = off_q + 32'd1; cnt = div_quo; pairs = {1'b0, len_q[31:1]};
    fail_f = 1'b0; fcode = StOk; er = '0;

    unique case (sq_q)
      SqIdle: if (in_acc) begin
        lastp_d = s_axis_tlast_i;
        sq_d = SqOut;
        case (ph_q)
          PhHead: begin
            tag_d = pb(tag_q, off_q[1:0], s_axis_tdata_i);
            off_d = offn;
            if (off_q == 32'd3 && tag_d != TagRiff) begin
              err_d = StRiff; ph_d = PhHalt;
            end else if (off_q == 32'd11) begin
              if (tag_d != TagWave) begin
                err_d = StWave; ph_d = PhHalt;
              end else begin
                ph_d = PhChdr; off_d = '0; tag_d = '0;
              end
            end
          end
          PhChdr: begin
            if (off_q[2] == 1'b0) tag_d = pb(tag_q, off_q[1:0], s_axis_tdata_i);
            else len_d = pb(len_q, off_q[1:0], s_axis_tdata_i);
            off_d = offn;
            if (off_q == 32'd7) begin
              off_d = '0;
              if (tag_d == TagFmt) begin
                gm_d = 1'b1; ph_d = PhFmt;
                if (len_d == 32'd0) begin
                  sq_d = SqDiv1; // fmt end check
                end
              end else if (tag_d == TagData) begin
                if (ch_q != 16'd1) begin err_d = StChannels; ph_d = PhHalt; end
                else if (bits_q != 16'd16) begin err_d = StBits; ph_d = PhHalt; end
                else if (rate_q != req_rate_q) begin err_d = StRate; ph_d = PhHalt; end
                else if (al_q == 16'd0) begin err_d = StZeroAlign; ph_d = PhHalt; end
                else begin
                  ph_d = PhData; sq_d = SqDivD;
                  div_start = 1'b1; div_num = len_d; div_den = {16'd0, al_q};
                end
              end else begin
                ph_d = PhSkip;
                if (len_d == 32'd0) ph_d = PhChdr;
              end
            end
          end
          PhFmt, PhData, PhSkip: begin
            if (ph_q == PhFmt) begin
              if (len_q >= 32'd14 && off_q < 32'd14) begin
                if (off_q < 32'd2)
                  fc_d = 16'(pb({16'd0, fc_q}, off_q[1:0], s_axis_tdata_i));
                else if (off_q < 32'd4)
                  ch_d = 16'(pb({16'd0, ch_q}, off_q[1:0] - 2'd2, s_axis_tdata_i));
                else if (off_q < 32'd8) rate_d = pb(rate_q, off_q[1:0], s_axis_tdata_i);
                else if (off_q < 32'd12) brate_d = pb(brate_q, off_q[1:0], s_axis_tdata_i);
                else al_d = 16'(pb({16'd0, al_q}, off_q[1:0], s_axis_tdata_i));
              end else if (len_q >= 32'd18 && off_q >= 32'd14 && off_q < 32'd18) begin
                if (off_q < 32'd16)
                  bits_d = 16'(pb({16'd0, bits_q}, off_q[1:0] - 2'd2, s_axis_tdata_i));
                else ext_d = 16'(pb({16'd0, ext_q}, off_q[1:0], s_axis_tdata_i));
              end else if (len_q >= 32'd40 && off_q >= 32'd18 && off_q < 32'd40) begin
                if (off_q < 32'd20)
                  vb_d = 16'(pb({16'd0, vb_q}, off_q[1:0] - 2'd2, s_axis_tdata_i));
                else if (off_q >= 32'd24 &&
                         s_axis_tdata_i != pcm_guid(off_q[3:0] - 4'd8)) gm_d = 1'b0;
              end
            end else if (ph_q == PhData && left_q != 32'd0) begin
              if (!off_q[0]) lo_d = s_axis_tdata_i;
              else begin
                r0_d = '0; r0_d.kind = KindSample;
                r0_d.sample = {s_axis_tdata_i, lo_q};
                nres_d = 2'd1; left_d = left_q - 32'd1;
              end
            end
            off_d = offn;
            if (offn == len_q) begin
              off_d = '0;
              if (ph_q == PhFmt) sq_d = SqDiv1;
              else ph_d = len_q[0] ? PhPad : PhChdr;
            end
          end
          PhPad: begin
            ph_d = PhChdr; off_d = '0;
          end
          default: ;
        endcase
        // fmt close with a short chunk needs the divider
        if (sq_d == SqDiv1) begin
          if (fc_d != CodecPcm && fc_d != CodecFloat && fc_d != CodecExt) begin
            err_d = StCodec; ph_d = PhHalt; sq_d = SqOut;
          end else if (len_d < 32'd18) begin
            if (rate_d == 32'd0 || ch_d == 16'd0) begin
              err_d = StZeroAlign; ph_d = PhHalt; sq_d = SqOut;
            end else begin
              div_start = 1'b1; div_num = brate_d; div_den = rate_d;
            end
          end else sq_d = SqDiv2; // no divide: finish checks next state
        end
      end
      SqDiv1: if (div_done) begin
        div_start = 1'b1; div_num = div_quo; div_den = {16'd0, ch_q};
        sq_d = SqDiv2;
      end
      SqDiv2: if (len_q >= 32'd18 || div_done) begin
        if (len_q < 32'd18) begin
          bits_d = {div_quo[12:0], 3'b000};
        end
        if (len_q >= 32'd40) begin
          if (fc_q != CodecExt) begin fail_f = 1'b1; fcode = StTag; end
          else if (ext_q < 16'd22) begin fail_f = 1'b1; fcode = StExtShort; end
          else if (vb_q != bits_d) begin fail_f = 1'b1; fcode = StValidBits; end
          else if (!gm_q) begin fail_f = 1'b1; fcode = StSubformat; end
        end else begin
          ext_d = '0; vb_d = bits_d;
        end
        if (fail_f) begin
          err_d = fcode; ph_d = PhHalt;
        end else begin
          fc_d = CodecPcm;
          ph_d = len_q[0] ? PhPad : PhChdr;
        end
        sq_d = SqOut;
      end
      SqDivD: if (div_done) begin
        r0_d = '0; r0_d.kind = KindStart; r0_d.sample_count = cnt;
        r0_d.channel_count = ch_q; r0_d.sample_bits = bits_q; r0_d.sample_rate = rate_q;
        nres_d = 2'd1;
        left_d = (cnt < pairs) ? cnt : pairs;
        acc_d = 1'b1;
        if (len_q == 32'd0) ph_d = PhChdr;
        sq_d = SqOut;
      end
      SqOut: begin
        if (out_acc) begin
          r0_d = r1_q; nres_d = nres_q - 2'd1;
        end
        if (nres_d == 2'd0) sq_d = SqIdle;
      end
      default: sq_d = SqIdle;
    endcase

    // end status joins the queue once the byte's own work is finished; a byte
    // that finishes in its accept cycle carries its last flag straight from the port
    if (((sq_q == SqIdle) ? s_axis_tlast_i : lastp_q) && sq_d == SqOut
        && sq_q != SqOut) begin
      er.kind = KindEnd; er.last = 1'b1;
      if (err_d != StOk) er.status = err_d;
      else if (!((ph_d == PhChdr && off_d == '0) || ph_d == PhPad)) er.status = StTrunc;
      else er.status = acc_d ? StOk : StNoData;
      if (nres_d == 2'd0) r0_d = er;
      else r1_d = er;
      nres_d = nres_d + 2'd1;
      lastp_d = 1'b0;
      ph_d = PhHead; off_d = '0; tag_d = '0; len_d = '0; fc_d = '0; ch_d = '0;
      rate_d = '0; brate_d = '0; al_d = '0; bits_d = '0; ext_d = '0; vb_d = '0;
      gm_d = 1'b1; lo_d = '0; left_d = '0; err_d = StOk; acc_d = 1'b0;
    end
    if (sq_d == SqOut && nres_d == 2'd0) sq_d = SqIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhHead; sq_q <= SqIdle; off_q <= '0; tag_q <= '0; len_q <= '0;
      fc_q <= '0; ch_q <= '0; rate_q <= '0; brate_q <= '0; al_q <= '0; bits_q <= '0;
      ext_q <= '0; vb_q <= '0; gm_q <= 1'b1; lo_q <= '0; left_q <= '0;
      err_q <= StOk; acc_q <= 1'b0; lastp_q <= 1'b0; nres_q <= '0;
    end else begin
      ph_q <= ph_d; sq_q <= sq_d; off_q <= off_d; tag_q <= tag_d; len_q <= len_d;
      fc_q <= fc_d; ch_q <= ch_d; rate_q <= rate_d; brate_q <= brate_d; al_q <= al_d;
      bits_q <= bits_d; ext_q <= ext_d; vb_q <= vb_d; gm_q <= gm_d; lo_q <= lo_d;
      left_q <= left_d; err_q <= err_d; acc_q <= acc_d; lastp_q <= lastp_d;
      nres_q <= nres_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d; r1_q <= r1_d;
  end

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nres_q != 2'd0) |-> !s_axis_tready_o) else $error("byte taken with results pending");
  a_halt_has_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PhHalt) |-> (err_q != StOk)) else $error("halt without error");
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == KindEnd) == m_axis_tlast_o))
    else $error("last flag mismatch");
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import whp_pkg::*;

  localparam int MaxIdle = 20000;

  // parser phases
  typedef enum logic [2:0] {
    PhHead, PhChdr, PhFmt, PhData, PhSkip, PhPad, PhHalt
  } phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } beat_t;

  localparam logic [1:0] AddrRate = 2'd0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [119:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         psel_i = 1'b0;
  logic         penable_i = 1'b0;
  logic         pwrite_i = 1'b0;
  logic [1:0]   paddr_i = '0;
  logic [31:0]  pwdata_i = '0;
  logic [31:0]  prdata_o;
  logic         pready_o;

  wave_header_parser_core DUT (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  logic [31:0] rate_reg;
  phase_e      ph;
  logic [31:0] off, tag, clen, fcode, chans, rate, brate, align, bits, extlen, vbits;
  logic        guid_ok, data_ok;
  logic [7:0]  lo_byte;
  logic [31:0] left;
  logic [3:0]  err;

  rec_t   expected_recs[$];
  beat_t  pending_beats[$];
  int     mismatches = 0;
  int     recs_seen = 0;
  int     files_sent = 0;
  int     beats_sent = 0;
  int     idle_cycles = 0;

  function automatic logic [7:0] guid_byte(int i);
    logic [7:0] g [16] = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00,
                           8'h80, 8'h00, 8'h00, 8'hAA, 8'h00, 8'h38, 8'h9B, 8'h71};
    return g[i];
  endfunction

  function automatic logic [31:0] set_byte(logic [31:0] f, logic [31:0] k, logic [7:0] b);
    logic [31:0] r;
    r = f;
    r[(k % 4) * 8 +: 8] = b;
    return r;
  endfunction

  task automatic clear_parser();
    ph = PhHead; off = 0; tag = 0; clen = 0; fcode = 0; chans = 0; rate = 0;
    brate = 0; align = 0; bits = 0; extlen = 0; vbits = 0; guid_ok = 1'b1;
    lo_byte = 0; left = 0; err = StOk; data_ok = 1'b0;
  endtask

  task automatic push_rec(logic [1:0] k, logic [15:0] s, logic [31:0] c, logic [15:0] ch,
                          logic [15:0] bt, logic [31:0] rt, logic [3:0] st, logic l);
    rec_t r;
    r.kind = k; r.sample = s; r.sample_count = c; r.channel_count = ch;
    r.sample_bits = bt; r.sample_rate = rt; r.status = st; r.last = l;
    expected_recs.push_back(r);
  endtask

  task automatic halt_with(logic [3:0] code);
    err = code;
    ph = PhHalt;
  endtask

  // fmt chunk checks once its last byte is in
  task automatic close_format();
    if (fcode[15:0] != CodecPcm && fcode[15:0] != CodecFloat && fcode[15:0] != CodecExt) begin
      halt_with(StCodec);
      return;
    end
    if (clen < 18) begin
      if (rate == 0 || chans == 0) begin
        halt_with(StZeroAlign);
        return;
      end
      bits = (((brate / rate) / chans) * 8) & 32'hFFFF;
      extlen = 0;
    end
    if (clen >= 40) begin
      if (fcode[15:0] != CodecExt) begin halt_with(StTag); return; end
      if (extlen < 22) begin halt_with(StExtShort); return; end
      if (vbits != bits) begin halt_with(StValidBits); return; end
      if (!guid_ok) begin halt_with(StSubformat); return; end
    end else begin
      extlen = 0;
      vbits = bits;
    end
    fcode = 1;
  endtask

  task automatic close_body();
    if (ph == PhFmt) begin
      close_format();
      if (ph == PhHalt) return;
    end
    off = 0;
    if (clen[0]) ph = PhPad;
    else ph = PhChdr;
  endtask

  task automatic open_body();
    logic [31:0] cnt, pairs;
    off = 0;
    if (tag == TagFmt) begin
      guid_ok = 1'b1;
      ph = PhFmt;
    end else if (tag == TagData) begin
      if (chans != 1) begin halt_with(StChannels); return; end
      if (bits != 16) begin halt_with(StBits); return; end
      if (rate != rate_reg) begin halt_with(StRate); return; end
      if (align == 0) begin halt_with(StZeroAlign); return; end
      cnt = clen / align;
      pairs = clen / 2;
      left = (cnt < pairs) ? cnt : pairs;
      data_ok = 1'b1;
      push_rec(KindStart, 0, cnt, chans[15:0], bits[15:0], rate, StOk, 1'b0);
      ph = PhData;
    end else begin
      ph = PhSkip;
    end
    if (clen == 0) close_body();
  endtask

  task automatic take_fmt_byte(logic [7:0] b);
    if (clen >= 14 && off < 14) begin
      if (off < 2) fcode = set_byte(fcode, off, b);
      else if (off < 4) chans = set_byte(chans, off - 2, b);
      else if (off < 8) rate = set_byte(rate, off - 4, b);
      else if (off < 12) brate = set_byte(brate, off - 8, b);
      else align = set_byte(align, off - 12, b);
    end else if (clen >= 18 && off >= 14 && off < 18) begin
      if (off < 16) bits = set_byte(bits, off - 14, b);
      else extlen = set_byte(extlen, off - 16, b);
    end else if (clen >= 40 && off >= 18 && off < 40) begin
      if (off < 20) vbits = set_byte(vbits, off - 18, b);
      else if (off >= 24 && b != guid_byte((off - 24) % 16)) guid_ok = 1'b0;
    end
  endtask

  // advance the parser model by one accepted byte
  task automatic parse_byte(beat_t bt);
    logic [3:0] st;
    case (ph)
      PhHead: begin
        tag = set_byte(tag, off, bt.b);
        if (off == 3 && tag != TagRiff) begin
          halt_with(StRiff);
        end else if (off == 11) begin
          if (tag != TagWave) halt_with(StWave);
          else begin
            ph = PhChdr; off = 0; tag = 0;
          end
        end else begin
          off++;
        end
      end
      PhChdr: begin
        if (off < 4) tag = set_byte(tag, off, bt.b);
        else clen = set_byte(clen, off - 4, bt.b);
        off++;
        if (off == 8) open_body();
      end
      PhFmt, PhData, PhSkip: begin
        if (ph == PhFmt) begin
          take_fmt_byte(bt.b);
        end else if (ph == PhData && left != 0) begin
          if (!off[0]) lo_byte = bt.b;
          else begin
            push_rec(KindSample, {bt.b, lo_byte}, 0, 0, 0, 0, StOk, 1'b0);
            left--;
          end
        end
        off++;
        if (off == clen) close_body();
      end
      PhPad: begin
        ph = PhChdr; off = 0;
      end
      default: ;
    endcase
    if (bt.last) begin
      if (err != StOk) st = err;
      else if (!((ph == PhChdr && off == 0) || ph == PhPad)) st = StTrunc;
      else st = data_ok ? StOk : StNoData;
      push_rec(KindEnd, 0, 0, 0, 0, 0, st, 1'b1);
      clear_parser();
    end
  endtask

  // ---------------------------------------------------------------- file builder
  logic [7:0] file_bytes[$];

  task automatic put8(logic [7:0] v);
    file_bytes.push_back(v);
  endtask
  task automatic put16(logic [15:0] v);
    put8(v[7:0]); put8(v[15:8]);
  endtask
  task automatic put32(logic [31:0] v);
    put16(v[15:0]); put16(v[31:16]);
  endtask

  task automatic put_head(bit bad_riff, bit bad_wave);
    put32(bad_riff ? TagRiff ^ (32'h1 << $urandom_range(31)) : TagRiff);
    put32($urandom);
    put32(bad_wave ? TagWave ^ (32'h1 << $urandom_range(31)) : TagWave);
  endtask

  // fmt chunk of a given length; fields beyond 40 are random filler
  task automatic put_fmt(logic [31:0] len, logic [15:0] codec, logic [15:0] ch,
                         logic [31:0] rt, logic [15:0] al, logic [15:0] bt,
                         logic [15:0] ext, logic [15:0] vb, bit bad_guid);
    logic [7:0] g;
    put32(TagFmt);
    put32(len);
    for (int i = 0; i < len; i++) begin
      case (i)
        0: g = codec[7:0];   1: g = codec[15:8];
        2: g = ch[7:0];      3: g = ch[15:8];
        4: g = rt[7:0];      5: g = rt[15:8];   6: g = rt[23:16]; 7: g = rt[31:24];
        8: g = 8'(rt * 2);   9: g = 8'((rt * 2) >> 8);
        10: g = 8'((rt * 2) >> 16);  11: g = 8'((rt * 2) >> 24);
        12: g = al[7:0];     13: g = al[15:8];
        14: g = bt[7:0];     15: g = bt[15:8];
        16: g = ext[7:0];    17: g = ext[15:8];
        18: g = vb[7:0];     19: g = vb[15:8];
        default: begin
          if (i >= 24 && i < 40) g = guid_byte(i - 24);
          else g = 8'($urandom);
        end
      endcase
      put8(g);
    end
    if (bad_guid && len >= 40) begin
      int p;
      p = file_bytes.size() - len + 24 + $urandom_range(15);
      file_bytes[p] = file_bytes[p] ^ (8'h1 << $urandom_range(7));
    end
    if (len[0]) put8($urandom);
  endtask

  task automatic put_chunk(logic [31:0] t, logic [31:0] len);
    put32(t);
    put32(len);
    for (int i = 0; i < len; i++) put8($urandom);
    if (len[0]) put8($urandom);
  endtask

  task automatic queue_file(int cut);
    int n;
    n = file_bytes.size();
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) begin
      beat_t bt;
      bt.b = file_bytes[i];
      bt.last = (i == n - 1);
      pending_beats.push_back(bt);
    end
    file_bytes.delete();
    files_sent++;
  endtask

  // random files; most get a corrupted field, no fmt chunk or an early end, a quarter are well-formed
  task automatic build_random_file();
    int flaw;
    int nchunks;
    logic [31:0] len;
    logic [15:0] codec;
    flaw = $urandom_range(0, 15);
    put_head(flaw == 1, flaw == 2);
    nchunks = $urandom_range(1, 3);
    if (flaw != 3) begin
      case ($urandom_range(0, 3))
        0: len = 16;
        1: len = 18;
        2: len = 40;
        default: len = $urandom_range(14, 45);
      endcase
      codec = (len >= 40) ? CodecExt : (($urandom_range(0, 1)) ? CodecPcm : CodecFloat);
      if (flaw == 4) codec = $urandom;
      put_fmt(len, codec, (flaw == 5) ? 16'($urandom_range(0, 3)) : 16'd1,
              (flaw == 6) ? $urandom : rate_reg,
              (flaw == 7) ? 16'd0 : 16'($urandom_range(1, 3)),
              (flaw == 8) ? 16'($urandom_range(0, 32)) : 16'd16,
              (flaw == 9) ? 16'($urandom_range(0, 21)) : 16'd22,
              (flaw == 10) ? 16'($urandom) : 16'd16, flaw == 11);
    end
    for (int c = 0; c < nchunks; c++) begin
      if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 9));
      put_chunk(TagData, $urandom_range(0, 30));
    end
    queue_file((flaw == 12) ? $urandom_range(1, 60) : 0);
  endtask

  task automatic queue_noise_file();
    int n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) put8($urandom);
    queue_file(0);
  endtask

  // ---------------------------------------------------------------- idle gaps
  int send_gap = 0;
  int recv_gap = 0;
  bit quiet_stretch = 1'b0;

  // returns 1 when the sender may present a beat this cycle
  function automatic bit gap_roll();
    if (send_gap > 0) begin
      send_gap--;
      return 1'b0;
    end
    if (!quiet_stretch) begin
      case ($urandom_range(0, 19))
        0: send_gap = $urandom_range(5, 40);
        1, 2, 3: send_gap = $urandom_range(1, 3);
        default: ;
      endcase
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        parse_byte('{s_axis_tdata_i, s_axis_tlast_i});
        beats_sent++;
      end
      if ((!s_axis_tvalid_i || s_axis_tready_o) && pending_beats.size() != 0
          && gap_roll()) begin
        beat_t bt;
        bt = pending_beats.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= bt.b;
        s_axis_tlast_i <= bt.last;
      end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_rec();
    rec_t got, want;
    got.kind = m_axis_tuser_o;
    got.sample = m_axis_tdata_o[15:0];
    got.sample_count = m_axis_tdata_o[47:16];
    got.channel_count = m_axis_tdata_o[63:48];
    got.sample_bits = m_axis_tdata_o[79:64];
    got.sample_rate = m_axis_tdata_o[111:80];
    got.status = m_axis_tdata_o[115:112];
    got.last = m_axis_tlast_o;
    recs_seen++;
    if (expected_recs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected record %p", got);
      return;
    end
    want = expected_recs.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("record mismatch: expected %p, got %p", want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_rec();
      if (s_axis_tvalid_i && s_axis_tready_o || m_axis_tvalid_o && m_axis_tready_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!quiet_stretch) begin
          case ($urandom_range(0, 19))
            0: recv_gap = $urandom_range(5, 40);
            1, 2, 3: recv_gap = $urandom_range(1, 3);
            default: ;
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (idle_cycles > MaxIdle) begin
      $display("watchdog: no beat for %0d cycles", MaxIdle);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- config
  task automatic write_rate(logic [31:0] v);
    @(posedge clk_i);
    psel_i <= 1'b1; penable_i <= 1'b0; pwrite_i <= 1'b1;
    paddr_i <= AddrRate; pwdata_i <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
    rate_reg = v;
  endtask

  // wait for the stream to drain, then for any divide still running
  task automatic drain();
    while (pending_beats.size() != 0 || s_axis_tvalid_i || expected_recs.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    logic [31:0] rates[4];
    rates = '{32'd44100, 32'd0, 32'hFFFF_FFFF, 32'd48000};
    rate_reg = 32'd44100;
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed files: each named case once
    put_head(0, 0); put_fmt(16, CodecPcm, 1, 44100, 2, 0, 0, 0, 0);
    put_chunk(TagData, 7); queue_file(0);                      // estimated bits, odd data
    put_head(0, 0); put_fmt(40, CodecExt, 1, 44100, 2, 16, 22, 16, 0);
    put32(TagData); put32(4); put32(32'h80007FFF); queue_file(0); // sample extremes
    put_head(1, 0); queue_file(0);                             // bad riff
    put_head(0, 1); queue_file(0);                             // bad wave
    put_head(0, 0); put_fmt(18, 16'h0002, 1, 44100, 2, 16, 0, 0, 0); queue_file(0);
    put_head(0, 0); put_fmt(40, CodecPcm, 1, 44100, 2, 16, 22, 16, 0); queue_file(0);
    put_head(0, 0); put_fmt(40, CodecExt, 1, 44100, 2, 16, 21, 16, 0); queue_file(0);
    put_head(0, 0); put_fmt(40, CodecExt, 1, 44100, 2, 16, 22, 24, 0); queue_file(0);
    put_head(0, 0); put_fmt(40, CodecExt, 1, 44100, 2, 16, 22, 16, 1); queue_file(0);
    put_head(0, 0); put_fmt(14, CodecFloat, 1, 0, 2, 0, 0, 0, 0); queue_file(0);
    put_head(0, 0); put_chunk(TagData, 4); queue_file(0);      // missing format
    put_head(0, 0); put_fmt(18, CodecPcm, 1, 44100, 2, 8, 0, 0, 0);
    put_chunk(TagData, 2); queue_file(0);                      // bits
    put_head(0, 0); put_fmt(18, CodecPcm, 1, 8000, 2, 16, 0, 0, 0);
    put_chunk(TagData, 2); queue_file(0);                      // rate
    put_head(0, 0); put_fmt(18, CodecPcm, 1, 44100, 0, 16, 0, 0, 0);
    put_chunk(TagData, 2); queue_file(0);                      // zero align
    put_head(0, 0); put_fmt(18, CodecPcm, 1, 44100, 3, 16, 0, 0, 0);
    put_chunk(TagData, 9); queue_file(0);                      // short chunk by align
    put_head(0, 0); put_chunk(32'h5453494C, 3); queue_file(0); // unknown only: nodata
    put_head(0, 0); put_fmt(16, CodecPcm, 1, 44100, 2, 0, 0, 0, 0);
    put_chunk(TagData, 10); queue_file(30);                    // truncated
    put_head(0, 0); put_fmt(16, CodecPcm, 1, 44100, 2, 0, 0, 0, 0);
    put_chunk(TagData, 0); queue_file(0);                      // empty data chunk
    drain();

    // every rate setting gets at least one random file
    for (int r = 0; r < 4; r++) begin
      write_rate(rates[r]);
      quiet_stretch = (r == 1);
      do begin
        if ($urandom_range(0, 9) == 0) queue_noise_file();
        else build_random_file();
        while (pending_beats.size() > 40) @(posedge clk_i);
      end while (beats_sent + pending_beats.size() < 950 * (r + 1) / 4);
      drain();
    end
    quiet_stretch = 1'b0;

    $display("files sent: %0d, beats: %0d, records checked: %0d",
             files_sent, beats_sent, recs_seen);
    $display("required rate swept over 44100, 0, max and 48000");
    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("mismatches: %0d, records left: %0d", mismatches, expected_recs.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/whp_pkg.sv
rtl/whp_div.sv
rtl/wave_header_parser_core.sv
tb/tb.sv
